### hw/rtl/mtsl_pkg.sv
// Shared types, codes and defaults for the two-way sorted merge block.
`timescale 1ns / 1ps

package mtsl_pkg;

  localparam int DEF_LIST_DEPTH  = 16;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int VALUE_BITS      = 32;  // width of the value fields on the ports
  localparam int QUEUE_DEPTH     = 4;   // command queue, power of two

  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_MERGE         = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH_FIRST,
    OP_PUSH_SECOND,
    OP_MERGE
  } op_kind_t;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [VALUE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] merged_value;
    logic                         last;
    logic                         dropped;
  } result_t;

  typedef struct packed {
    logic                  valid;
    op_kind_t              kind;
    logic [VALUE_BITS-1:0] value;
  } queue_head_t;

endpackage

### hw/rtl/mtsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mtsl_front.sv
// Front end: takes command beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module mtsl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mtsl_pkg::item_t     item,
  output logic                busy,
  output mtsl_pkg::queue_head_t head,
  input  logic                pop
);
  import mtsl_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [PW:0]           fill;
  logic [PW:0]           fill_next;
  op_kind_t              kind_q  [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] value_q [QUEUE_DEPTH];

  logic     push;
  logic     enq;
  op_kind_t kind;

  // Unused command code is accepted and discarded here.
  always_comb begin
    push = 1'b0;
    kind = OP_MERGE;
    case (item.cmd)
      CMD_APPEND_FIRST: begin
        push = 1'b1;
        kind = OP_PUSH_FIRST;
      end
      CMD_APPEND_SECOND: begin
        push = 1'b1;
        kind = OP_PUSH_SECOND;
      end
      CMD_MERGE: begin
        push = 1'b1;
        kind = OP_MERGE;
      end
      default: begin
        push = 1'b0;
        kind = OP_MERGE;
      end
    endcase
  end

  assign busy = (fill == (PW + 1)'(QUEUE_DEPTH));
  assign enq  = start && !busy && push;

  always_comb begin
    case ({enq, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      kind_q[wr_ptr]  <= kind;
      value_q[wr_ptr] <= item.value;
    end
  end

  assign head.valid = (fill != '0);
  assign head.kind  = kind_q[rd_ptr];
  assign head.value = value_q[rd_ptr];

endmodule

### hw/rtl/mtsl_back.sv
// Back end: appends into the two stores and runs the merge, with a store read between two results.
`timescale 1ns / 1ps

module mtsl_back #(
  parameter int LIST_DEPTH  = mtsl_pkg::DEF_LIST_DEPTH,
  parameter int VALUE_WIDTH = mtsl_pkg::DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mtsl_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  strobe,
  output mtsl_pkg::result_t     result
);
  import mtsl_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int RW = $clog2(2 * LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt_a;
  logic [CW-1:0]   cnt_b;
  logic [CW-1:0]   idx_a;
  logic [CW-1:0]   idx_b;
  logic [RW-1:0]   remain;
  logic            drop_flag;

  logic                      we_a;
  logic                      we_b;
  logic [VALUE_WIDTH-1:0]    wdata;
  logic [VALUE_WIDTH-1:0]    rdata_a;
  logic [VALUE_WIDTH-1:0]    rdata_b;
  logic [VALUE_WIDTH+VALUE_BITS-1:0] in_wide;
  logic [VALUE_WIDTH+VALUE_BITS-1:0] out_wide;
  logic [RW-1:0]             total;
  logic                      full_a;
  logic                      full_b;
  logic                      valid_a;
  logic                      valid_b;
  logic                      take_a;
  logic [VALUE_WIDTH-1:0]    pick;

  assign pop    = (state == ST_IDLE) && head.valid;
  assign full_a = (cnt_a == CW'(LIST_DEPTH));
  assign full_b = (cnt_b == CW'(LIST_DEPTH));
  assign we_a   = pop && (head.kind == OP_PUSH_FIRST) && !full_a;
  assign we_b   = pop && (head.kind == OP_PUSH_SECOND) && !full_b;

  // Resize the port value to the store width (truncate or zero-extend).
  assign in_wide = {{VALUE_WIDTH{1'b0}}, head.value};
  assign wdata   = in_wide[VALUE_WIDTH-1:0];

  assign total = RW'(cnt_a) + RW'(cnt_b);

  // Tie goes to the first store.
  assign valid_a = (idx_a < cnt_a);
  assign valid_b = (idx_b < cnt_b);
  assign take_a  = valid_a && (!valid_b || ($signed(rdata_a) <= $signed(rdata_b)));
  assign pick    = take_a ? rdata_a : rdata_b;
  assign out_wide = {{VALUE_BITS{1'b0}}, pick};

  mtsl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_a[AW-1:0]),
    .rdata (rdata_a)
  );

  mtsl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_b[AW-1:0]),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      idx_a     <= '0;
      idx_b     <= '0;
      remain    <= '0;
      drop_flag <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.kind)
              OP_PUSH_FIRST: begin
                if (full_a) begin
                  drop_flag <= 1'b1;
                end else begin
                  cnt_a <= cnt_a + 1'b1;
                end
              end
              OP_PUSH_SECOND: begin
                if (full_b) begin
                  drop_flag <= 1'b1;
                end else begin
                  cnt_b <= cnt_b + 1'b1;
                end
              end
              OP_MERGE: begin
                idx_a  <= '0;
                idx_b  <= '0;
                remain <= total;
                if (total == '0) begin
                  drop_flag <= 1'b0;
                end else begin
                  state <= ST_LOAD;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LOAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe              <= 1'b1;
          result.merged_value <= out_wide[VALUE_BITS-1:0];
          result.last         <= (remain == RW'(1));
          result.dropped      <= drop_flag;
          remain              <= remain - 1'b1;
          if (take_a) begin
            idx_a <= idx_a + 1'b1;
          end else begin
            idx_b <= idx_b + 1'b1;
          end
          if (remain == RW'(1)) begin
            cnt_a     <= '0;
            cnt_b     <= '0;
            drop_flag <= 1'b0;
            state     <= ST_IDLE;
          end else begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/merge_two_sorted_lists.sv
// Top level of the two-way merge of two sorted sequences.
`timescale 1ns / 1ps

// Channel   Handshake          Payload                           Direction
// command   start / busy       item   (cmd, value)               in
// result    strobe, no stall   result (merged_value, last,       out
//                                      dropped)
//
// An append beat is handled in the back end's idle state; a merge leaves that
// state and then takes a store read, then a compare and emit, per emitted
// value, because the read of the two store RAMs is registered.
// Reset (rst, synchronous) empties the command queue and both stores and
// clears the drop flag; store contents are not cleared.
// busy is high only while the command queue is full; command beats keep
// landing in the queue during a merge. Results cannot be stalled.

module merge_two_sorted_lists #(
  parameter int LIST_DEPTH  = mtsl_pkg::DEF_LIST_DEPTH,
  parameter int VALUE_WIDTH = mtsl_pkg::DEF_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mtsl_pkg::item_t   item,
  output logic              busy,
  output logic              strobe,
  output mtsl_pkg::result_t result
);
  import mtsl_pkg::*;

  queue_head_t head;
  logic        pop;

  // Front: accepts beats, drops the unused code, queues the rest.
  mtsl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  // Back: owns the stores, counts and drop flag; runs the merge.
  mtsl_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  // Back end needs a store read between two results.
  a_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("results on consecutive cycles");

  // Within a run the next result follows after a single store read state.
  a_cadence: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> ##2 strobe)
    else $error("merge run broke its cadence");

  // The drop flag is constant over one run.
  a_drop_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> ##2 (result.dropped == $past(result.dropped, 2)))
    else $error("dropped changed within a run");

  // After reset the queue is empty and nothing is emitted.
  a_reset: assert property (@(posedge clk) rst |=> (!busy && !strobe))
    else $error("busy or strobe after reset");
`endif

endmodule

### tb/tb_merge_two_sorted_lists.sv
// Self-checking testbench for the two-way merge of two sorted sequences.
`timescale 1ns / 1ps

module tb_merge_two_sorted_lists;
  import mtsl_pkg::*;

  // Store depth of the block under test; the predictor refuses pushes past it.
  localparam int LIST_DEPTH = DEF_LIST_DEPTH;
  // No cycle of a correct run goes this long without a command beat or a result.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last result; a merge holds at most 2*LIST_DEPTH values.
  localparam int DRAIN_CYCLES = 100;
  // The fourth command code; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic signed [VALUE_BITS-1:0] word_t;
  typedef word_t word_q_t[$];

  localparam word_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam word_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  merge_two_sorted_lists uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #1 clk = ~clk;

  // Stimulus backlog, filled up front and drained by the driver.
  item_t   cmd_backlog[$];
  // Merged values still owed by the block, oldest first.
  result_t pending_merged[$];

  // Predictor state: what each store holds, and the refused-push flag.
  word_t first_held[$];
  word_t second_held[$];
  bit    drop_seen;

  // Driver bookkeeping.
  bit    holding;      // start is up with cmd_now on the item port
  bit    beat_taken;   // a command beat was accepted at the last rising edge
  item_t cmd_now;
  int    gap_left;
  int    calm_left;    // beats left in a stretch with no idling

  int    idle_cycles;
  bit    run_done;
  int    err_count;
  int    n_beats;
  int    n_merges;
  int    n_drop_runs;
  int    n_checked;

  task automatic add_beat(input logic [1:0] c, input logic [VALUE_BITS-1:0] v);
    item_t it;
    it.cmd   = c;
    it.value = v;
    cmd_backlog.push_back(it);
  endtask

  // Builds one list of n values; mode picks wide, narrow (many ties) or extremes.
  function automatic word_q_t make_run(input int n, input int mode, input bit ordered);
    word_q_t q;
    word_t   w;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = $urandom;
        1: begin
          w = $urandom_range(0, 8);
          w = w - 4;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: w = VAL_MIN;
            1: w = VAL_MAX;
            2: w = 0;
            3: w = -1;
            4: w = VAL_MIN + 1;
            default: w = VAL_MAX - 1;
          endcase
        end
      endcase
      q.push_back(w);
    end
    if (ordered) q.sort();
    return q;
  endfunction

  // Applies one accepted command beat to the predictor state.
  task automatic predict_beat(input item_t it);
    result_t r;
    int      total;
    int      n;
    bit      take_first;
    n_beats++;
    case (it.cmd)
      CMD_APPEND_FIRST: begin
        if (first_held.size() < LIST_DEPTH) first_held.push_back(it.value);
        else drop_seen = 1'b1;
      end
      CMD_APPEND_SECOND: begin
        if (second_held.size() < LIST_DEPTH) second_held.push_back(it.value);
        else drop_seen = 1'b1;
      end
      CMD_MERGE: begin
        total = first_held.size() + second_held.size();
        n = 0;
        n_merges++;
        if (drop_seen) n_drop_runs++;
        while (first_held.size() > 0 || second_held.size() > 0) begin
          // Ties go to the first list.
          if (first_held.size() > 0 && second_held.size() > 0)
            take_first = first_held[0] <= second_held[0];
          else
            take_first = first_held.size() > 0;
          if (take_first) r.merged_value = first_held.pop_front();
          else r.merged_value = second_held.pop_front();
          n++;
          r.last    = (n == total);
          r.dropped = drop_seen;
          pending_merged.push_back(r);
        end
        // An empty merge still clears the refused-push flag.
        drop_seen = 1'b0;
      end
      default: ;  // unused code: no state change
    endcase
  endtask

  // Driver: changes the command port only at falling edges.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (holding && beat_taken) begin
        holding = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 11);
          if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 30);
        end
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cmd_now = cmd_backlog.pop_front();
          holding = 1'b1;
        end
      end
      start <= holding;
      if (holding) item <= cmd_now;
    end
  end

  // Monitor and predictor: everything sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (strobe) begin
        if (pending_merged.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: value %0d last %0b dropped %0b", $time,
                   result.merged_value, result.last, result.dropped);
        end else begin
          automatic result_t want = pending_merged.pop_front();
          n_checked++;
          if (result.merged_value !== want.merged_value || result.last !== want.last ||
              result.dropped !== want.dropped) begin
            err_count++;
            $display("%0t: mismatch: expected %0d last %0b drop %0b, got %0d last %0b drop %0b",
                     $time, want.merged_value, want.last, want.dropped,
                     result.merged_value, result.last, result.dropped);
          end
        end
      end
      if (start && !busy) predict_beat(item);
      beat_taken <= start && !busy;
    end
  end

  // Watchdog: ends the run if the block goes quiet with work outstanding.
  always @(posedge clk) begin
    if (rst || run_done || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat or result for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    word_q_t run_a;
    word_q_t run_b;
    int      na;
    int      nb;
    int      ia;
    int      ib;
    int      mode;
    int      seq;
    int      random_beats;
    bit      ordered;
    bit      pick_first;

    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    holding     = 1'b0;
    beat_taken  = 1'b0;
    gap_left    = 0;
    calm_left   = 0;
    drop_seen   = 1'b0;
    idle_cycles = 0;
    run_done    = 1'b0;
    err_count   = 0;
    n_beats     = 0;
    n_merges    = 0;
    n_drop_runs = 0;
    n_checked   = 0;

    // Directed: unused code, empty merge, extremes with ties at VAL_MIN, -1 and
    // VAL_MAX, one list empty, single element.
    add_beat(CMD_UNUSED, '1);
    add_beat(CMD_MERGE, '0);
    add_beat(CMD_APPEND_FIRST, VAL_MIN);
    add_beat(CMD_APPEND_FIRST, -1);
    add_beat(CMD_APPEND_FIRST, 0);
    add_beat(CMD_APPEND_FIRST, VAL_MAX);
    add_beat(CMD_APPEND_SECOND, VAL_MIN);
    add_beat(CMD_APPEND_SECOND, -1);
    add_beat(CMD_APPEND_SECOND, VAL_MAX);
    add_beat(CMD_MERGE, '1);
    add_beat(CMD_APPEND_SECOND, -5);
    add_beat(CMD_APPEND_SECOND, 5);
    add_beat(CMD_MERGE, '0);
    add_beat(CMD_APPEND_FIRST, 7);
    add_beat(CMD_MERGE, '0);

    // Random: mostly sorted lists pushed in random interleave, then in most runs a merge.
    // The first run overfills the first store so a refused push is certain.
    seq = 0;
    random_beats = 0;
    while (random_beats < 80) begin
      if (seq == 0) begin
        na = LIST_DEPTH + 1;
        nb = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 2);
      end else if ($urandom_range(0, 99) < 12) begin
        na = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 2);
        nb = $urandom_range(0, LIST_DEPTH + 2);
      end else begin
        na = $urandom_range(0, 5);
        nb = $urandom_range(0, 5);
      end
      mode    = $urandom_range(0, 2);
      ordered = ($urandom_range(0, 9) != 0);
      run_a   = make_run(na, mode, ordered);
      run_b   = make_run(nb, mode, ordered);
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
        if (ia < na && ib < nb) pick_first = $urandom_range(0, 1);
        else pick_first = (ia < na);
        if (pick_first) begin
          add_beat(CMD_APPEND_FIRST, run_a[ia]);
          ia++;
        end else begin
          add_beat(CMD_APPEND_SECOND, run_b[ib]);
          ib++;
        end
        random_beats++;
        if ($urandom_range(0, 99) < 5) add_beat(CMD_UNUSED, $urandom);
      end
      // Now and then leave the lists standing into the next run.
      if ($urandom_range(0, 9) != 0) begin
        add_beat(CMD_MERGE, $urandom);
        random_beats++;
      end
      seq++;
    end
    add_beat(CMD_MERGE, $urandom);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || holding || pending_merged.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done = 1'b1;

    $display("summary: %0d command beats, %0d merges (%0d after a refused push)",
             n_beats, n_merges, n_drop_runs);
    $display("summary: %0d merged values checked, %0d errors", n_checked, err_count);
    if (err_count == 0 && pending_merged.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
